// ===== design/lsma_pkg.sv =====
// Shared types and codes for the limb scalar multiply-accumulate unit.
package lsma_pkg;

  localparam int FIELD_W = 64;

  typedef enum logic [1:0] {
    OP_MUL          = 2'd0,
    OP_ADD_IN_PLACE = 2'd1,
    OP_ADD_TO_SRC   = 2'd2,
    OP_SUB          = 2'd3
  } op_mode_t;

  // Register index, taken from paddr[3].
  localparam logic REG_OP_MODE    = 1'b0;
  localparam logic REG_MULTIPLIER = 1'b1;

  typedef struct packed {
    logic [FIELD_W-1:0] mult_limb;
    logic [FIELD_W-1:0] acc_limb;
    logic               first_limb;
    logic [FIELD_W-1:0] carry_in;
    logic               last_limb;
  } item_t;

  typedef struct packed {
    logic [FIELD_W-1:0] result_limb;
    logic [FIELD_W-1:0] carry_out;
    logic               run_end;
  } result_t;

  typedef struct packed {
    op_mode_t           op_mode;
    logic [FIELD_W-1:0] multiplier_word;
  } cfg_t;

endpackage

// ===== design/lsma_front.sv =====
// Front end: accepts words, runs the split limb product and classifies by mode.
module lsma_front #(
  parameter int LIMB_BITS   = 64,
  parameter int QUEUE_DEPTH = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  lsma_pkg::cfg_t         cfg,
  input  lsma_pkg::item_t        item,
  input  logic                   push,
  output logic                   full,
  input  logic                   q_pop,
  output logic                   q_push,
  output logic [5*LIMB_BITS+4:0] q_data
);
  import lsma_pkg::*;

  localparam int LO_H  = LIMB_BITS / 2;
  localparam int HI_H  = LIMB_BITS - LO_H;
  localparam int XW    = LIMB_BITS + 2;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [XW-1:0]        x;
    logic [LIMB_BITS-1:0] phi;
    logic [LIMB_BITS-1:0] phi1;
    logic [LIMB_BITS-1:0] phi2;
    logic [LIMB_BITS-1:0] cin;
    logic                 sub;
    logic                 first;
    logic                 last;
  } entry_t;

  typedef struct packed {
    logic [LIMB_BITS-1:0] a;
    logic [LIMB_BITS-1:0] cin;
    logic                 first;
    logic                 last;
    op_mode_t             op;
  } side_t;

  logic                 accept;
  logic [CNT_W-1:0]     held;
  logic [CNT_W-1:0]     held_next;
  logic                 v1, v2, v3, v4;
  logic [LO_H-1:0]      b0, w0;
  logic [HI_H-1:0]      b1, w1;
  logic [2*LO_H-1:0]    s1_p00;
  logic [LIMB_BITS-1:0] s1_p01;
  logic [LIMB_BITS-1:0] s1_p10;
  logic [2*HI_H-1:0]    s1_p11;
  side_t                s1_side, s2_side, s3_side;
  logic [LIMB_BITS:0]   s2_mid;
  logic [2*LIMB_BITS-1:0] s2_cat;
  logic [2*LIMB_BITS-1:0] s3_prod;
  logic [LIMB_BITS-1:0] phi, plo;
  entry_t               s4_entry_next;
  entry_t               s4_entry;

  assign accept = push && !full;
  // Credit covers every word in the product pipeline and in the queue.
  assign full   = (held == CNT_W'(QUEUE_DEPTH));

  assign b0 = item.mult_limb[LO_H-1:0];
  assign b1 = item.mult_limb[LIMB_BITS-1:LO_H];
  assign w0 = cfg.multiplier_word[LO_H-1:0];
  assign w1 = cfg.multiplier_word[LIMB_BITS-1:LO_H];

  always_comb begin
    unique case ({accept, q_pop})
      2'b10:   held_next = held + CNT_W'(1);
      2'b01:   held_next = held - CNT_W'(1);
      default: held_next = held;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= '0;
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      v4   <= 1'b0;
    end else begin
      held <= held_next;
      v1   <= accept;
      v2   <= v1;
      v3   <= v2;
      v4   <= v3;
    end
  end

  assign phi = s3_prod[2*LIMB_BITS-1:LIMB_BITS];
  assign plo = s3_prod[LIMB_BITS-1:0];

  // In the add and subtract modes the accumulator is folded into the low product
  // here, so that the back end only has to add or subtract the running carry.
  always_comb begin
    s4_entry_next.phi   = phi;
    s4_entry_next.phi1  = phi + LIMB_BITS'(1);
    s4_entry_next.phi2  = phi + LIMB_BITS'(2);
    s4_entry_next.cin   = s3_side.cin;
    s4_entry_next.first = s3_side.first;
    s4_entry_next.last  = s3_side.last;
    s4_entry_next.sub   = (s3_side.op == OP_SUB);
    unique case (s3_side.op)
      OP_MUL:                        s4_entry_next.x = XW'(plo);
      OP_ADD_IN_PLACE, OP_ADD_TO_SRC: s4_entry_next.x = XW'(s3_side.a) + XW'(plo);
      OP_SUB:                        s4_entry_next.x = XW'(s3_side.a) - XW'(plo);
    endcase
  end

  always_ff @(posedge clk) begin
    s1_p00        <= (2*LO_H)'(b0) * (2*LO_H)'(w0);
    s1_p01        <= LIMB_BITS'(b0) * LIMB_BITS'(w1);
    s1_p10        <= LIMB_BITS'(b1) * LIMB_BITS'(w0);
    s1_p11        <= (2*HI_H)'(b1) * (2*HI_H)'(w1);
    s1_side.a     <= item.acc_limb[LIMB_BITS-1:0];
    s1_side.cin   <= item.carry_in[LIMB_BITS-1:0];
    s1_side.first <= item.first_limb;
    s1_side.last  <= item.last_limb;
    s1_side.op    <= cfg.op_mode;

    s2_mid        <= (LIMB_BITS+1)'(s1_p01) + (LIMB_BITS+1)'(s1_p10);
    s2_cat        <= {s1_p11, s1_p00};
    s2_side       <= s1_side;

    s3_prod       <= s2_cat + ((2*LIMB_BITS)'(s2_mid) << LO_H);
    s3_side       <= s2_side;

    s4_entry      <= s4_entry_next;
  end

  assign q_push = v4;
  assign q_data = s4_entry;

  held_in_range: assert property (@(posedge clk) disable iff (rst)
    held <= CNT_W'(QUEUE_DEPTH))
    else $error("front credit count exceeds queue depth");

  held_tracks_accept: assert property (@(posedge clk) disable iff (rst)
    accept && !q_pop |=> held == $past(held) + CNT_W'(1))
    else $error("front credit count missed an accepted word");

endmodule

// ===== design/lsma_queue.sv =====
// Short queue that parts the product pipeline from the carry stage.
module lsma_queue #(
  parameter int WIDTH = 325,
  parameter int DEPTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             avail
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] ptr);
    return (ptr == PTR_W'(DEPTH - 1)) ? '0 : ptr + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= bump(wr_ptr);
      if (pop) rd_ptr <= bump(rd_ptr);
      unique case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

  assign pop_data = slots[rd_ptr];
  assign avail    = (count != '0);

  no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> count != CNT_W'(DEPTH))
    else $error("queue written while full");

  no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != '0)
    else $error("queue read while empty");

endmodule

// ===== design/lsma_back.sv =====
// Back end: adds or subtracts the running carry, picks the next carry and holds the result word.
module lsma_back #(
  parameter int LIMB_BITS = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   q_avail,
  input  logic [5*LIMB_BITS+4:0] q_data,
  output logic                   q_pop,
  input  logic                   pop,
  output logic                   empty,
  output lsma_pkg::result_t      result
);
  import lsma_pkg::*;

  localparam int XW = LIMB_BITS + 2;

  typedef struct packed {
    logic [XW-1:0]        x;
    logic [LIMB_BITS-1:0] phi;
    logic [LIMB_BITS-1:0] phi1;
    logic [LIMB_BITS-1:0] phi2;
    logic [LIMB_BITS-1:0] cin;
    logic                 sub;
    logic                 first;
    logic                 last;
  } entry_t;

  entry_t               e;
  logic                 out_valid;
  logic                 advance;
  logic [LIMB_BITS-1:0] running_carry;
  logic [LIMB_BITS-1:0] c;
  logic [XW-1:0]        sum;
  logic [1:0]           upper;
  logic [1:0]           t;
  logic [LIMB_BITS-1:0] nc;
  result_t              result_next;

  assign e       = q_data;
  assign advance = q_avail && (!out_valid || pop);
  assign q_pop   = advance;
  assign empty   = !out_valid;

  // The top two bits of the sum give how many carries (or borrows, negated)
  // leave this limb; the product high limb was offered with 0, 1 and 2 added.
  always_comb begin
    c     = e.first ? e.cin : running_carry;
    sum   = e.sub ? e.x - XW'(c) : e.x + XW'(c);
    upper = sum[XW-1:LIMB_BITS];
    t     = e.sub ? 2'b00 - upper : upper;
    unique case (t)
      2'd0:    nc = e.phi;
      2'd1:    nc = e.phi1;
      default: nc = e.phi2;
    endcase
    result_next.result_limb = FIELD_W'(sum[LIMB_BITS-1:0]);
    result_next.carry_out   = FIELD_W'(nc);
    result_next.run_end     = e.last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid     <= 1'b0;
      running_carry <= '0;
    end else if (advance) begin
      out_valid     <= 1'b1;
      running_carry <= nc;
    end else if (pop) begin
      out_valid     <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) result <= result_next;
  end

  carry_follows_result: assert property (@(posedge clk) disable iff (rst)
    advance |=> running_carry == result.carry_out[LIMB_BITS-1:0])
    else $error("running carry differs from the carry just delivered");

  drained_when_idle: assert property (@(posedge clk) disable iff (rst)
    pop && !empty && !q_avail |=> empty)
    else $error("result word shown twice");

endmodule

// ===== design/limb_scalar_mul_accumulate_unit.sv =====
// Top level of the limb scalar multiply-accumulate unit with its register port.
//
//   channel   handshake             payload
//   input     push / full           item   (mult_limb, acc_limb, first_limb, carry_in, last_limb)
//   result    empty / pop           result (result_limb, carry_out, run_end)
//   config    psel/penable/pwrite   paddr, pwdata, prdata (op_mode at 0, multiplier_word at 8)
//
// One word is taken per cycle while full is low; each accepted word then passes
// the four product stages, the queue and the carry stage before its result appears.
// The rate is set by the running carry loop: one LIMB_BITS+2 bit add and a select.
// Reset clears the registers, the running carry and all valid and count state.
// full rises once QUEUE_DEPTH words sit in the product stages and the queue;
// a stalled result side fills the queue and the input side stalls only then.
module limb_scalar_mul_accumulate_unit #(
  parameter int LIMB_BITS   = 64,
  parameter int QUEUE_DEPTH = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [63:0]       pwdata,
  output logic [63:0]       prdata,
  output logic              pready,
  input  lsma_pkg::item_t   item,
  input  logic              push,
  output logic              full,
  output lsma_pkg::result_t result,
  output logic              empty,
  input  logic              pop
);
  import lsma_pkg::*;

  localparam int ENTRY_W = 5 * LIMB_BITS + 5;

  cfg_t                 cfg;
  logic                 cfg_write;
  logic                 q_push, q_pop, q_avail;
  logic [ENTRY_W-1:0]   q_in, q_out;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.op_mode         <= OP_MUL;
      cfg.multiplier_word <= '0;
    end else if (cfg_write) begin
      unique case (paddr[3])
        REG_OP_MODE:    cfg.op_mode         <= op_mode_t'(pwdata[1:0]);
        REG_MULTIPLIER: cfg.multiplier_word <= pwdata;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3])
      REG_OP_MODE:    prdata = {62'b0, cfg.op_mode};
      REG_MULTIPLIER: prdata = cfg.multiplier_word;
    endcase
  end

  lsma_front #(
    .LIMB_BITS  (LIMB_BITS),
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .item  (item),
    .push  (push),
    .full  (full),
    .q_pop (q_pop),
    .q_push(q_push),
    .q_data(q_in)
  );

  lsma_queue #(
    .WIDTH(ENTRY_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_data(q_in),
    .pop      (q_pop),
    .pop_data (q_out),
    .avail    (q_avail)
  );

  lsma_back #(
    .LIMB_BITS(LIMB_BITS)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .q_avail(q_avail),
    .q_data (q_out),
    .q_pop  (q_pop),
    .pop    (pop),
    .empty  (empty),
    .result (result)
  );

endmodule
